@@ sv/rdf_pkg.sv @@
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared types, codes, microprogram and helper functions of the radix digit
// formatter.
// ----------------------------------------------------------------------------
package rdf_pkg;

    // Field widths
    localparam int VALUE_W   = 16;
    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 7;
    localparam int CHUNK_W   = 8;
    localparam int PROD_W    = VALUE_W + RADIX_W;
    localparam int PC_W      = 4;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DIGITS  = 16;
    localparam int DEF_FRAC_DIGITS = 3;

    // Radix clamp limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_0   = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_9   = 7'd57;
    localparam logic [CHAR_W-1:0] CHAR_A   = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_F   = 7'd70;
    localparam logic [CHAR_W-1:0] CHAR_DOT = 7'd46;
    localparam logic [RADIX_W-1:0] DEC_TEN = 5'd10;

    // Datapath operations
    typedef logic [2:0] t_op;
    localparam t_op OP_NOP       = 3'd0;
    localparam t_op OP_LOAD      = 3'd1;
    localparam t_op OP_DIV_HI    = 3'd2;
    localparam t_op OP_DIV_LO    = 3'd3;
    localparam t_op OP_READ      = 3'd4;
    localparam t_op OP_EMIT_INT  = 3'd5;
    localparam t_op OP_EMIT_DOT  = 3'd6;
    localparam t_op OP_EMIT_FRAC = 3'd7;

    // Jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond COND_NEXT      = 3'd0;
    localparam t_cond COND_ALWAYS    = 3'd1;
    localparam t_cond COND_INT_DONE  = 3'd2;
    localparam t_cond COND_CNT_ZERO  = 3'd3;
    localparam t_cond COND_CNT_MORE  = 3'd4;
    localparam t_cond COND_FRAC_MORE = 3'd5;

    // Step numbers of the microprogram
    typedef logic [PC_W-1:0] t_pc;
    localparam t_pc PC_TEST   = 4'd0;
    localparam t_pc PC_DIV_HI = 4'd1;
    localparam t_pc PC_DIV_LO = 4'd2;
    localparam t_pc PC_READ   = 4'd3;
    localparam t_pc PC_EMIT_I = 4'd4;
    localparam t_pc PC_DOT    = 4'd5;
    localparam t_pc PC_MUL    = 4'd6;
    localparam t_pc PC_EMIT_F = 4'd7;
    localparam t_pc PC_LOAD   = 4'd8;

    // Control word and status
    typedef struct packed {
        logic  mul;
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uop;

    typedef struct packed {
        logic  mul;
        t_op   op;
        logic  go;
    } t_ctrl;

    typedef struct packed {
        logic int_done;
        logic cnt_zero;
        logic cnt_more;
        logic frac_more;
        logic out_free;
    } t_status;

    // Microprogram ROM
    function automatic t_uop ucode(input t_pc pc);
        t_uop u;
        u = '{mul: 1'b0, op: OP_LOAD, cond: COND_ALWAYS, target: PC_TEST};
        case (pc)
            PC_TEST:   u = '{mul: 1'b0, op: OP_NOP,       cond: COND_INT_DONE,
                             target: PC_READ};
            PC_DIV_HI: u = '{mul: 1'b0, op: OP_DIV_HI,    cond: COND_NEXT,
                             target: PC_TEST};
            PC_DIV_LO: u = '{mul: 1'b0, op: OP_DIV_LO,    cond: COND_ALWAYS,
                             target: PC_TEST};
            PC_READ:   u = '{mul: 1'b0, op: OP_READ,      cond: COND_CNT_ZERO,
                             target: PC_DOT};
            PC_EMIT_I: u = '{mul: 1'b0, op: OP_EMIT_INT,  cond: COND_CNT_MORE,
                             target: PC_READ};
            PC_DOT:    u = '{mul: 1'b0, op: OP_EMIT_DOT,  cond: COND_NEXT,
                             target: PC_TEST};
            PC_MUL:    u = '{mul: 1'b1, op: OP_NOP,       cond: COND_NEXT,
                             target: PC_TEST};
            PC_EMIT_F: u = '{mul: 1'b0, op: OP_EMIT_FRAC, cond: COND_FRAC_MORE,
                             target: PC_MUL};
            PC_LOAD:   u = '{mul: 1'b0, op: OP_LOAD,      cond: COND_ALWAYS,
                             target: PC_TEST};
            default:   u = '{mul: 1'b0, op: OP_LOAD,      cond: COND_ALWAYS,
                             target: PC_TEST};
        endcase
        return u;
    endfunction

    // Eight restoring division steps on one byte of the dividend.
    // Result is {quotient byte, remainder}.
    function automatic logic [CHUNK_W+DIGIT_W-1:0] div_step8(
        input logic [DIGIT_W-1:0] rem_in,
        input logic [CHUNK_W-1:0] bits,
        input logic [RADIX_W-1:0] rdx
    );
        logic [RADIX_W-1:0] rem;
        logic [CHUNK_W-1:0] q;
        rem = {1'b0, rem_in};
        q   = '0;
        for (int k = CHUNK_W - 1; k >= 0; k--) begin
            rem = {rem[DIGIT_W-1:0], bits[k]};
            if (rem >= rdx) begin
                rem  = rem - rdx;
                q[k] = 1'b1;
            end
        end
        return {q, rem[DIGIT_W-1:0]};
    endfunction

    // Digit to ASCII: 0-9 as '0'-'9', 10 and up as 'A' + (d - 10)
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DEC_TEN) begin
            c = CHAR_A + CHAR_W'(d - DEC_TEN);
        end else begin
            c = CHAR_0 + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

@@ sv/rdf_digit_mem.sv @@
// ----------------------------------------------------------------------------
// rdf_digit_mem
// Digit stack: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rdf_digit_mem import rdf_pkg::*; #(
    parameter int DEPTH = DEF_MAX_DIGITS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [DIGIT_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [DIGIT_W-1:0] o_rdata
);

    logic [DIGIT_W-1:0] r_mem [DEPTH];
    logic [DIGIT_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rdf_datapath.sv @@
// ----------------------------------------------------------------------------
// rdf_datapath
// Operand registers, shared byte divider, fraction multiplier, digit stack
// and output register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module rdf_datapath import rdf_pkg::*; #(
    parameter int MAX_DIGITS  = DEF_MAX_DIGITS,
    parameter int FRAC_DIGITS = DEF_FRAC_DIGITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl              i_ctrl,
    input  logic [VALUE_W-1:0] i_int_part,
    input  logic [VALUE_W-1:0] i_frac_part,
    input  logic [RADIX_W-1:0] i_radix,
    input  logic               i_stall,
    output t_status            o_status,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_char_code,
    output logic               o_last_char
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int FW = $clog2(FRAC_DIGITS + 1);

    logic [VALUE_W-1:0]         r_value;
    logic [VALUE_W-1:0]         r_frac;
    logic [RADIX_W-1:0]         r_radix;
    logic [CHUNK_W-1:0]         r_qhi;
    logic [DIGIT_W-1:0]         r_rem;
    logic [CW-1:0]              r_cnt;
    logic [FW-1:0]              r_fcnt;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_out_valid;
    logic [CHAR_W-1:0]          r_char;
    logic                       r_last;

    logic [RADIX_W-1:0]         w_radix;
    logic                       w_div_hi;
    logic [CHUNK_W+DIGIT_W-1:0] w_div;
    logic [CW-1:0]              w_cnt_dec;
    logic [DIGIT_W-1:0]         w_rdata;
    logic                       w_emit;
    logic                       w_frac_last;
    logic                       w_we;
    logic                       w_re;

    // clamp the radix into 2..16
    always_comb begin
        if (i_radix < RADIX_MIN) begin
            w_radix = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            w_radix = RADIX_MAX;
        end else begin
            w_radix = i_radix;
        end
    end

    // shared divider: high byte with zero remainder, then low byte
    assign w_div_hi = (i_ctrl.op == OP_DIV_HI);
    assign w_div    = div_step8(w_div_hi ? '0 : r_rem,
                                w_div_hi ? r_value[VALUE_W-1:CHUNK_W]
                                         : r_value[CHUNK_W-1:0],
                                r_radix);

    assign w_cnt_dec   = r_cnt - CW'(1);
    assign w_we        = i_ctrl.go && (i_ctrl.op == OP_DIV_LO);
    assign w_re        = i_ctrl.go && (i_ctrl.op == OP_READ);
    assign w_frac_last = (r_fcnt == FW'(FRAC_DIGITS - 1));
    assign w_emit      = i_ctrl.go && ((i_ctrl.op == OP_EMIT_INT) ||
                                       (i_ctrl.op == OP_EMIT_DOT) ||
                                       (i_ctrl.op == OP_EMIT_FRAC));

    // digit stack, least significant digit pushed first
    rdf_digit_mem #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_div[DIGIT_W-1:0]),
        .i_re    (w_re),
        .i_raddr (w_cnt_dec[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // operand and working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.go && i_ctrl.mul) begin
            r_prod <= PROD_W'(r_frac) * PROD_W'(r_radix);
        end
        if (i_ctrl.go) begin
            case (i_ctrl.op)
                OP_LOAD: begin
                    r_value <= i_int_part;
                    r_frac  <= i_frac_part;
                    r_radix <= w_radix;
                    r_cnt   <= '0;
                    r_fcnt  <= '0;
                end
                OP_DIV_HI: begin
                    r_qhi <= w_div[CHUNK_W+DIGIT_W-1:DIGIT_W];
                    r_rem <= w_div[DIGIT_W-1:0];
                end
                OP_DIV_LO: begin
                    r_value <= {r_qhi, w_div[CHUNK_W+DIGIT_W-1:DIGIT_W]};
                    r_cnt   <= r_cnt + CW'(1);
                end
                OP_EMIT_INT: begin
                    r_cnt <= w_cnt_dec;
                end
                OP_EMIT_FRAC: begin
                    r_frac <= r_prod[VALUE_W-1:0];
                    r_fcnt <= r_fcnt + FW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // output register: valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register: payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            case (i_ctrl.op)
                OP_EMIT_INT:  r_char <= digit_char({1'b0, w_rdata});
                OP_EMIT_FRAC: r_char <= digit_char(r_prod[PROD_W-1:VALUE_W]);
                default:      r_char <= CHAR_DOT;
            endcase
            r_last <= (i_ctrl.op == OP_EMIT_FRAC) && w_frac_last;
        end
    end

    // status for the sequencer's jumps and holds
    assign o_status.int_done  = (r_value == '0) || (r_cnt == CW'(MAX_DIGITS));
    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.cnt_more  = (r_cnt > CW'(1));
    assign o_status.frac_more = !w_frac_last;
    assign o_status.out_free  = !r_out_valid || !i_stall;

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule

@@ sv/rdf_seq.sv @@
// ----------------------------------------------------------------------------
// rdf_seq
// Microprogram sequencer: step counter, control ROM, holds and jumps.
// ----------------------------------------------------------------------------
module rdf_seq import rdf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_ctrl   o_ctrl,
    output logic    o_stall
);

    t_pc  r_pc;
    t_pc  n_pc;
    t_uop w_uop;
    logic w_hold;
    logic w_jump;
    logic w_emit;

    assign w_uop  = ucode(r_pc);
    assign w_emit = (w_uop.op == OP_EMIT_INT) || (w_uop.op == OP_EMIT_DOT) ||
                    (w_uop.op == OP_EMIT_FRAC);

    // a step waits for a request on input, or for room in the output register
    assign o_stall = (w_uop.op != OP_LOAD);
    assign w_hold  = ((w_uop.op == OP_LOAD) && !i_valid) ||
                     (w_emit && !i_status.out_free);

    // jump condition
    always_comb begin
        case (w_uop.cond)
            COND_NEXT:      w_jump = 1'b0;
            COND_ALWAYS:    w_jump = 1'b1;
            COND_INT_DONE:  w_jump = i_status.int_done;
            COND_CNT_ZERO:  w_jump = i_status.cnt_zero;
            COND_CNT_MORE:  w_jump = i_status.cnt_more;
            COND_FRAC_MORE: w_jump = i_status.frac_more;
            default:        w_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_jump) begin
            n_pc = w_uop.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.mul = w_uop.mul;
    assign o_ctrl.op  = w_uop.op;
    assign o_ctrl.go  = !w_hold;

endmodule

@@ sv/radix_digit_formatter.sv @@
// ----------------------------------------------------------------------------
// radix_digit_formatter
// Converts an unsigned integer part and a Q0.16 fraction to ASCII text in a
// radix from 2 to 16, one character per output request.
// ----------------------------------------------------------------------------
// One number is worked at a time. Each integer digit costs three sequencer
// steps in the shared byte divider (test, high byte, low byte) and two on the
// way out through the single read port of the digit stack; each fraction
// digit is one multiply step and one output step. Output stalls hold the
// output steps. A radix below 2 is used as 2 and one above 16 as 16; only the
// MAX_DIGITS least significant integer digits are emitted. The last fraction
// character carries o_last_char.
// ----------------------------------------------------------------------------
module radix_digit_formatter import rdf_pkg::*; #(
    parameter int MAX_DIGITS  = DEF_MAX_DIGITS,
    parameter int FRAC_DIGITS = DEF_FRAC_DIGITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_int_part,
    input  logic [VALUE_W-1:0] i_frac_part,
    input  logic [RADIX_W-1:0] i_radix,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CHAR_W-1:0]  o_char_code,
    output logic               o_last_char
);

    t_ctrl   w_ctrl;
    t_status w_status;

    // sequencer
    rdf_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_ctrl   (w_ctrl),
        .o_stall  (o_stall)
    );

    // datapath
    rdf_datapath #(
        .MAX_DIGITS  (MAX_DIGITS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_int_part  (i_int_part),
        .i_frac_part (i_frac_part),
        .i_radix     (i_radix),
        .i_stall     (i_stall),
        .o_status    (w_status),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    // an accepted request moves the sequencer off its load step
    a_leave_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("sequencer still accepting after a request");

    // the decimal point never closes a number
    a_dot_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_char_code == CHAR_DOT)) |-> !o_last_char)
        else $error("decimal point flagged as last character");

    // only digits 0-9, A-F or the point leave the block
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_char_code == CHAR_DOT) ||
                     ((o_char_code >= CHAR_0) && (o_char_code <= CHAR_9)) ||
                     ((o_char_code >= CHAR_A) && (o_char_code <= CHAR_F))))
        else $error("illegal character code");

    // a stalled character holds until it is taken
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_char_code) &&
                                  $stable(o_last_char)))
        else $error("stalled output changed");

endmodule

@@ tb/sv/radix_digit_formatter_tb.sv @@
// ----------------------------------------------------------------------------
// radix_digit_formatter_tb
// Self-checking bench for the radix digit formatter. Numbers are fed from a
// queue through a randomly idling driver. Every accepted request is expanded
// into its expected characters by a local predictor. A monitor with random
// stalls and periodic long hold-offs compares each character as it leaves.
// ----------------------------------------------------------------------------
module radix_digit_formatter_tb import rdf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int INT_DIGITS     = DEF_MAX_DIGITS;
    localparam int FRAC_DIGITS    = DEF_FRAC_DIGITS;
    localparam int RANDOM_NUMBERS = 350;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_PERIOD    = 10000;
    localparam int HOLD_START     = 2000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int CYCLE_LIMIT    = 1000000;

    typedef struct packed {
        logic [VALUE_W-1:0] int_part;
        logic [VALUE_W-1:0] frac_part;
        logic [RADIX_W-1:0] radix;
    } t_number;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } t_text_char;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic [VALUE_W-1:0] i_int_part  = '0;
    logic [VALUE_W-1:0] i_frac_part = '0;
    logic [RADIX_W-1:0] i_radix     = RADIX_MIN;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic [CHAR_W-1:0]  o_char_code;
    logic               o_last_char;

    t_number    pending_numbers[$];
    t_text_char expected_text[$];
    t_number    offered_number;
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         accepted_count = 0;
    int         total_numbers  = 0;
    int         send_wait      = 0;
    int         recv_wait      = 0;
    int         hold_left      = 0;
    bit         send_burst     = 1'b0;
    bit         recv_burst     = 1'b0;

    radix_digit_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_int_part  (i_int_part),
        .i_frac_part (i_frac_part),
        .i_radix     (i_radix),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    // Clock and cycle count
    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Digit value to ASCII
    function automatic logic [CHAR_W-1:0] ascii_digit(input logic [RADIX_W-1:0] d);
        if (d >= DEC_TEN) begin
            return CHAR_A + CHAR_W'(d % DEC_TEN);
        end
        return CHAR_0 + CHAR_W'(d);
    endfunction

    // Expands one number into the characters it should produce
    function automatic void push_expected_text(input t_number num);
        logic [RADIX_W-1:0] base;
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] fraction;
        logic [PROD_W-1:0]  product;
        logic [RADIX_W-1:0] int_digits[INT_DIGITS];
        int                 ndig;
        base = num.radix;
        if (base < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (base > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        // integer digits, least significant found first
        rest = num.int_part;
        ndig = 0;
        while (rest != 0 && ndig < INT_DIGITS) begin
            int_digits[ndig] = RADIX_W'(rest % base);
            rest = rest / base;
            ndig++;
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            expected_text.push_back('{char_code: ascii_digit(int_digits[k]), last_char: 1'b0});
        end
        expected_text.push_back('{char_code: CHAR_DOT, last_char: 1'b0});
        // fraction digits by multiply and truncate
        fraction = num.frac_part;
        for (int k = 0; k < FRAC_DIGITS; k++) begin
            product  = fraction * base;
            fraction = product[VALUE_W-1:0];
            expected_text.push_back('{char_code: ascii_digit(product[PROD_W-1:VALUE_W]),
                                      last_char: (k == FRAC_DIGITS - 1)});
        end
    endfunction

    // Idle cycles per request or stall cycles per character; burst stretches draw none
    function automatic int draw_wait(input bit burst);
        if (burst) begin
            return 0;
        end
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 16);
        end
        return $urandom_range(0, 2);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0d] mismatch: %s", cycle_count, what);
    endtask

    // Driver: offers queued numbers, idles between requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                push_expected_text(offered_number);
                accepted_count++;
                if ($urandom_range(0, 29) == 0) begin
                    send_burst = !send_burst;
                end
                send_wait = draw_wait(send_burst);
            end
            // a stalled request stays as it is
            if (!(i_valid && o_stall)) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (pending_numbers.size() != 0) begin
                    offered_number = pending_numbers.pop_front();
                    i_int_part  <= offered_number.int_part;
                    i_frac_part <= offered_number.frac_part;
                    i_radix     <= offered_number.radix;
                    i_valid     <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (cycle_count % HOLD_PERIOD == HOLD_START) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor: checks characters, stalls at random
    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                              o_char_code, o_last_char));
                end else begin
                    want = expected_text.pop_front();
                    if (o_char_code !== want.char_code) begin
                        report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                                  o_char_code, want.char_code));
                    end
                    if (o_last_char !== want.last_char) begin
                        report_mismatch($sformatf("last_char %0b, want %0b",
                                                  o_last_char, want.last_char));
                    end
                end
                if ($urandom_range(0, 29) == 0) begin
                    recv_burst = !recv_burst;
                end
                recv_wait = draw_wait(recv_burst);
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Timeout
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus, reset and end of run
    initial begin
        t_number num;
        int      pick;
        // directed: extremes, clamped radices, letter digits
        pending_numbers.push_back('{int_part: 16'h0000, frac_part: 16'h0000, radix: 5'd2});
        pending_numbers.push_back('{int_part: 16'hFFFF, frac_part: 16'hFFFF, radix: 5'd2});
        pending_numbers.push_back('{int_part: 16'hFFFF, frac_part: 16'hFFFF, radix: 5'd16});
        pending_numbers.push_back('{int_part: 16'd12345, frac_part: 16'h8000, radix: 5'd10});
        pending_numbers.push_back('{int_part: 16'd0, frac_part: 16'hFFFF, radix: 5'd16});
        pending_numbers.push_back('{int_part: 16'd1, frac_part: 16'h0001, radix: 5'd16});
        pending_numbers.push_back('{int_part: 16'd77, frac_part: 16'h4000, radix: 5'd0});
        pending_numbers.push_back('{int_part: 16'd77, frac_part: 16'h4000, radix: 5'd1});
        pending_numbers.push_back('{int_part: 16'hBEEF, frac_part: 16'hC0DE, radix: 5'd17});
        pending_numbers.push_back('{int_part: 16'hFFFF, frac_part: 16'hFFFF, radix: 5'd31});
        pending_numbers.push_back('{int_part: 16'hFFFF, frac_part: 16'hAAAA, radix: 5'd3});
        pending_numbers.push_back('{int_part: 16'd10, frac_part: 16'hE000, radix: 5'd11});
        pending_numbers.push_back('{int_part: 16'hA5A5, frac_part: 16'h5A5A, radix: 5'd13});
        pending_numbers.push_back('{int_part: 16'd2400, frac_part: 16'h1234, radix: 5'd7});
        pending_numbers.push_back('{int_part: 16'd255, frac_part: 16'hFFFF, radix: 5'd15});
        pending_numbers.push_back('{int_part: 16'd0, frac_part: 16'h0000, radix: 5'd16});
        // random numbers, mostly in range
        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                num.int_part = '0;
            end else if (pick < 3) begin
                num.int_part = VALUE_W'($urandom_range(0, 255));
            end else begin
                num.int_part = VALUE_W'($urandom);
            end
            num.frac_part = (pick == 9) ? '1 : VALUE_W'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                num.radix = RADIX_W'($urandom_range(0, 31));
            end else begin
                num.radix = RADIX_W'($urandom_range(2, 16));
            end
            pending_numbers.push_back(num);
        end
        total_numbers = pending_numbers.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count != total_numbers) begin
            @(posedge i_clk);
        end
        while (expected_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ radix_digit_formatter.f @@
sv/rdf_pkg.sv
sv/rdf_digit_mem.sv
sv/rdf_datapath.sv
sv/rdf_seq.sv
sv/radix_digit_formatter.sv
tb/sv/radix_digit_formatter_tb.sv
